@@ sv/samc_pkg.sv @@
// Shared types, codes and constants for the speed and angle motor command unit.
`timescale 1ns / 1ps

package samc_pkg;

  // Sizing
  localparam int NUM_MOTORS_DEF = 4;
  localparam int FIELD_MOTORS   = 4;   // motors that have register fields
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  // Limits and reset values
  localparam logic [6:0]  SPEED_MAX   = 7'd100;
  localparam logic [7:0]  ANGLE_MAX   = 8'd180;
  localparam logic [7:0]  ANGLE_RESET = 8'd90;

  localparam logic [3:0]  KIND_MASK_RST    = 4'h0;
  localparam logic [27:0] SPEED_SCALES_RST = 28'd211366500;
  localparam logic [31:0] ANGLE_MIN_RST    = 32'd0;
  localparam logic [31:0] ANGLE_MAX_RST    = 32'd3031741620;
  localparam logic [31:0] ANGLE_CENTER_RST = 32'd1515870810;

  // x / 100 for x below 10000 as (x * 5243) >> 19
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND_MASK    = 3'd0,
    REG_SPEED_SCALES = 3'd1,
    REG_ANGLE_MIN    = 3'd2,
    REG_ANGLE_MAX    = 3'd3,
    REG_ANGLE_CENTER = 3'd4
  } cfg_reg_t;

  // Command opcodes
  typedef enum logic [2:0] {
    OP_SET_SPEED  = 3'd0,
    OP_STEP_SPEED = 3'd1,
    OP_SET_ANGLE  = 3'd2,
    OP_STEP_ANGLE = 3'd3,
    OP_START      = 3'd4,
    OP_STOP       = 3'd5
  } opcode_t;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    CMD_ERROR,
    CMD_SPEED,
    CMD_ANGLE,
    CMD_START,
    CMD_STOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        step;
    logic [1:0]  motor;
    logic [1:0]  direction;
    logic [8:0]  amount;     // two's complement
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        drive_valid;
    logic [1:0]  drive_motor;
    logic [1:0]  drive_direction;
    logic        drive_is_angle;
    logic [7:0]  drive_value;
    logic        power_changed;
    logic        power_on;
    logic        last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_MUL,
    BK_DIV,
    BK_WALK,
    BK_OUT
  } back_state_t;

endpackage

@@ sv/samc_cfg.sv @@
// Configuration registers and per-motor limit, scale and center decode.
`timescale 1ns / 1ps

module samc_cfg #(
  parameter int NUM_MOTORS = samc_pkg::NUM_MOTORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [samc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [samc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [3:0]                       kind_mask,
  output logic [NUM_MOTORS-1:0]            is_angle,
  output logic [6:0]                       scale   [NUM_MOTORS],
  output logic [7:0]                       amin    [NUM_MOTORS],
  output logic [7:0]                       amax    [NUM_MOTORS],
  output logic [7:0]                       center  [NUM_MOTORS]
);

  logic [3:0]  kind_mask_r;
  logic [27:0] speed_scales_r;
  logic [31:0] angle_min_r;
  logic [31:0] angle_max_r;
  logic [31:0] angle_center_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_mask_r    <= samc_pkg::KIND_MASK_RST;
      speed_scales_r <= samc_pkg::SPEED_SCALES_RST;
      angle_min_r    <= samc_pkg::ANGLE_MIN_RST;
      angle_max_r    <= samc_pkg::ANGLE_MAX_RST;
      angle_center_r <= samc_pkg::ANGLE_CENTER_RST;
    end else if (cfg_we) begin
      unique case (samc_pkg::cfg_reg_t'(cfg_index))
        samc_pkg::REG_KIND_MASK:    kind_mask_r    <= cfg_wdata[3:0];
        samc_pkg::REG_SPEED_SCALES: speed_scales_r <= cfg_wdata[27:0];
        samc_pkg::REG_ANGLE_MIN:    angle_min_r    <= cfg_wdata[31:0];
        samc_pkg::REG_ANGLE_MAX:    angle_max_r    <= cfg_wdata[31:0];
        samc_pkg::REG_ANGLE_CENTER: angle_center_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign kind_mask = kind_mask_r;

  // Per-motor fields, saturated; motors without fields are speed motors, all zero
  for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_motor
    if (i < samc_pkg::FIELD_MOTORS) begin : g_field
      logic [6:0] sc_raw;
      logic [7:0] lo_raw, hi_raw, c_raw, lo, hi, c;
      assign sc_raw = speed_scales_r[7*i +: 7];
      assign lo_raw = angle_min_r[8*i +: 8];
      assign hi_raw = angle_max_r[8*i +: 8];
      assign c_raw  = angle_center_r[8*i +: 8];
      assign lo = (lo_raw > samc_pkg::ANGLE_MAX) ? samc_pkg::ANGLE_MAX : lo_raw;
      assign hi = (hi_raw > samc_pkg::ANGLE_MAX) ? samc_pkg::ANGLE_MAX : hi_raw;
      assign c  = (c_raw  > samc_pkg::ANGLE_MAX) ? samc_pkg::ANGLE_MAX : c_raw;
      assign is_angle[i] = kind_mask_r[i];
      assign scale[i]    = (sc_raw > samc_pkg::SPEED_MAX) ? samc_pkg::SPEED_MAX : sc_raw;
      assign amin[i]     = lo;
      assign amax[i]     = hi;
      // below minimum wins over above maximum
      assign center[i]   = (c < lo) ? lo : ((c > hi) ? hi : c);
    end else begin : g_none
      assign is_angle[i] = 1'b0;
      assign scale[i]    = 7'd0;
      assign amin[i]     = 8'd0;
      assign amax[i]     = 8'd0;
      assign center[i]   = 8'd0;
    end
  end

endmodule

@@ sv/samc_front.sv @@
// Command intake: accepts input words and classifies them for the back end.
`timescale 1ns / 1ps

module samc_front #(
  parameter int NUM_MOTORS = samc_pkg::NUM_MOTORS_DEF
) (
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [15:0]             in_tdata,
  input  logic [3:0]              kind_mask,
  input  samc_pkg::queue_status_t q_status,
  output logic                    q_push,
  output samc_pkg::cmd_t          q_word
);

  logic [2:0] opcode;
  logic [1:0] motor;
  logic       bad_motor;
  logic       angle_motor;

  assign opcode = in_tdata[2:0];
  assign motor  = in_tdata[4:3];

  assign bad_motor   = ({2'b00, motor} >= 4'(NUM_MOTORS));
  assign angle_motor = kind_mask[motor];

  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && !q_status.full;

  // Classify by opcode, motor range and motor kind
  always_comb begin
    q_word           = '0;
    q_word.step      = opcode[0];
    q_word.motor     = motor;
    q_word.direction = in_tdata[6:5];
    q_word.amount    = in_tdata[15:7];
    unique case (samc_pkg::opcode_t'(opcode)) inside
      samc_pkg::OP_SET_SPEED, samc_pkg::OP_STEP_SPEED: begin
        q_word.kind = (bad_motor || angle_motor) ? samc_pkg::CMD_ERROR : samc_pkg::CMD_SPEED;
      end
      samc_pkg::OP_SET_ANGLE, samc_pkg::OP_STEP_ANGLE: begin
        q_word.kind = (bad_motor || !angle_motor) ? samc_pkg::CMD_ERROR : samc_pkg::CMD_ANGLE;
      end
      samc_pkg::OP_START: q_word.kind = samc_pkg::CMD_START;
      samc_pkg::OP_STOP:  q_word.kind = samc_pkg::CMD_STOP;
      default:            q_word.kind = samc_pkg::CMD_ERROR;
    endcase
  end

endmodule

@@ sv/samc_queue.sv @@
// Small register queue between command intake and execution.
`timescale 1ns / 1ps

module samc_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = samc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    pop,
  output logic [WIDTH-1:0]        rdata,
  output samc_pkg::queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/samc_back.sv @@
// Command execution: setpoints, power flag, drive scaling and result register.
`timescale 1ns / 1ps

module samc_back #(
  parameter int NUM_MOTORS = samc_pkg::NUM_MOTORS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  samc_pkg::queue_status_t q_status,
  input  samc_pkg::cmd_t          q_word,
  output logic                    q_pop,
  input  logic [NUM_MOTORS-1:0]   is_angle,
  input  logic [6:0]              scale  [NUM_MOTORS],
  input  logic [7:0]              amin   [NUM_MOTORS],
  input  logic [7:0]              amax   [NUM_MOTORS],
  input  logic [7:0]              center [NUM_MOTORS],
  output logic                    out_valid,
  input  logic                    out_ready,
  output samc_pkg::result_t       out_res
);

  localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  samc_pkg::back_state_t state_r, state_nxt;
  samc_pkg::cmd_t        cmd_r, cmd_nxt;
  samc_pkg::result_t     res_r, res_nxt;
  samc_pkg::result_t     out_res_r, out_res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  power_r, power_nxt;
  logic [6:0]            speed_sp_r [NUM_MOTORS];
  logic [6:0]            speed_sp_nxt [NUM_MOTORS];
  logic [7:0]            angle_sp_r [NUM_MOTORS];
  logic [7:0]            angle_sp_nxt [NUM_MOTORS];
  logic [13:0]           prod_r, prod_nxt;
  logic [MIDX_W-1:0]     idx_r, idx_nxt;

  logic                  slot_free;
  logic                  walk_done;
  logic [MIDX_W-1:0]     sel_idx;
  logic [6:0]            sp_cur;
  logic [7:0]            ang_cur, lo_cur, hi_cur;
  logic signed [9:0]     amt_ext, lo_ext, hi_ext;
  logic signed [9:0]     spd_sum, ang_sum;
  logic [6:0]            spd_new;
  logic [7:0]            ang_new;
  logic [26:0]           recip_prod;
  logic [7:0]            quot;
  samc_pkg::result_t     base_res;

  assign slot_free = !out_valid_r || out_ready;
  assign walk_done = (idx_r == MIDX_W'(NUM_MOTORS - 1));
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Operand selection for the addressed motor
  assign sel_idx = MIDX_W'(cmd_r.motor);
  assign sp_cur  = speed_sp_r[sel_idx];
  assign ang_cur = angle_sp_r[sel_idx];
  assign lo_cur  = amin[sel_idx];
  assign hi_cur  = amax[sel_idx];
  assign amt_ext = $signed({cmd_r.amount[8], cmd_r.amount});
  assign lo_ext  = $signed({2'b00, lo_cur});
  assign hi_ext  = $signed({2'b00, hi_cur});

  // New setpoints: absolute or relative, then clamped
  assign spd_sum = (cmd_r.step ? $signed({3'b000, sp_cur}) : 10'sd0) + amt_ext;
  assign ang_sum = (cmd_r.step ? $signed({2'b00, ang_cur}) : 10'sd0) + amt_ext;
  assign spd_new = (spd_sum < 10'sd0) ? 7'd0 :
                   ((spd_sum > $signed({3'b000, samc_pkg::SPEED_MAX})) ?
                    samc_pkg::SPEED_MAX : spd_sum[6:0]);
  assign ang_new = (ang_sum < lo_ext) ? lo_cur :
                   ((ang_sum > hi_ext) ? hi_cur : ang_sum[7:0]);

  // Percent scaling: divide by 100 through the reciprocal
  assign recip_prod = 27'(prod_r) * 27'(samc_pkg::RECIP_100);
  assign quot       = recip_prod[samc_pkg::RECIP_SHIFT +: 8];

  // Result with no drive, current power state
  always_comb begin
    base_res          = '0;
    base_res.power_on = power_r;
    base_res.last     = 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      samc_pkg::BK_IDLE: begin
        if (!q_status.empty) state_nxt = samc_pkg::BK_EXEC;
      end
      samc_pkg::BK_EXEC: begin
        unique case (cmd_r.kind)
          samc_pkg::CMD_SPEED: state_nxt = samc_pkg::BK_MUL;
          samc_pkg::CMD_START: state_nxt = power_r ? samc_pkg::BK_WALK : samc_pkg::BK_OUT;
          default:             state_nxt = samc_pkg::BK_OUT;
        endcase
      end
      samc_pkg::BK_MUL:  state_nxt = samc_pkg::BK_DIV;
      samc_pkg::BK_DIV:  state_nxt = samc_pkg::BK_OUT;
      samc_pkg::BK_WALK: begin
        if (slot_free && walk_done) state_nxt = samc_pkg::BK_OUT;
      end
      samc_pkg::BK_OUT: begin
        if (slot_free) state_nxt = samc_pkg::BK_IDLE;
      end
      default: state_nxt = samc_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    q_pop         = 1'b0;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    power_nxt     = power_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    speed_sp_nxt  = speed_sp_r;
    angle_sp_nxt  = angle_sp_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      samc_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_word;
        end
      end
      samc_pkg::BK_EXEC: begin
        res_nxt = base_res;
        unique case (cmd_r.kind) inside
          samc_pkg::CMD_SPEED: begin
            speed_sp_nxt[sel_idx] = spd_new;
          end
          samc_pkg::CMD_ANGLE: begin
            angle_sp_nxt[sel_idx] = ang_new;
            if (power_r) begin
              res_nxt.drive_valid    = 1'b1;
              res_nxt.drive_motor    = cmd_r.motor;
              res_nxt.drive_is_angle = 1'b1;
              res_nxt.drive_value    = ang_new;
            end
          end
          samc_pkg::CMD_START, samc_pkg::CMD_STOP: begin
            // every motor back to rest
            for (int i = 0; i < NUM_MOTORS; i++) begin
              if (is_angle[i]) angle_sp_nxt[i] = center[i];
              else             speed_sp_nxt[i] = 7'd0;
            end
            if (cmd_r.kind == samc_pkg::CMD_START) begin
              power_nxt             = 1'b1;
              idx_nxt               = '0;
              res_nxt.power_on      = 1'b1;
              res_nxt.power_changed = !power_r;
            end else begin
              power_nxt             = 1'b0;
              res_nxt.power_on      = 1'b0;
              res_nxt.power_changed = power_r;
            end
          end
          default: begin
            res_nxt.status = 1'b1;
          end
        endcase
      end
      samc_pkg::BK_MUL: begin
        prod_nxt = 14'(sp_cur) * 14'(scale[sel_idx]);
      end
      samc_pkg::BK_DIV: begin
        if (power_r) begin
          res_nxt.drive_valid     = 1'b1;
          res_nxt.drive_motor     = cmd_r.motor;
          res_nxt.drive_direction = cmd_r.direction;
          res_nxt.drive_value     = quot;
        end
      end
      samc_pkg::BK_WALK: begin
        // one drive word per motor, in index order
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_res_nxt                = '0;
          out_res_nxt.drive_valid    = 1'b1;
          out_res_nxt.drive_motor    = 2'(idx_r);
          out_res_nxt.drive_is_angle = is_angle[idx_r];
          out_res_nxt.drive_value    = is_angle[idx_r] ? center[idx_r] : 8'd0;
          out_res_nxt.power_on       = 1'b1;
          idx_nxt                    = idx_r + 1'b1;
        end
      end
      samc_pkg::BK_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end
      default: ;
    endcase
  end

  // Control state and setpoints
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= samc_pkg::BK_IDLE;
      power_r     <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        speed_sp_r[i] <= 7'd0;
        angle_sp_r[i] <= samc_pkg::ANGLE_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      power_r     <= power_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      speed_sp_r  <= speed_sp_nxt;
      angle_sp_r  <= angle_sp_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    prod_r    <= prod_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

@@ sv/speed_and_angle_motor_command_unit.sv @@
// Top level of the speed and angle motor command unit.
//
// Input channel (in_*): one command word per handshake, opcode, motor,
// direction and amount packed in in_tdata. Result channel (out_*): one or
// more result words per command, the final one marked by out_tlast, with
// out_tuser telling whether the drive value is an angle.
// Configuration port (cfg_*): a write of register cfg_index takes effect at
// the clock edge where cfg_we is high; write only while no command is open.
//
// A command passes a two-word queue and is then executed one at a time.
// The result is registered after the queue and the execute and output states;
// speed commands first pass a multiply state for the percent scaling and a
// divide state for the reciprocal divide by 100. A start with power already
// on emits NUM_MOTORS drive words, one per cycle while the receiver is ready,
// then the power word. The execution sequencer takes the next command once
// the last result is in the result register.
// Reset: power off, speeds 0, angles 90, registers at their defaults.
// A stalled receiver holds the result register; the queue keeps accepting
// commands until it is full.
`timescale 1ns / 1ps

module speed_and_angle_motor_command_unit #(
  parameter int NUM_MOTORS = samc_pkg::NUM_MOTORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // opcode[2:0], motor_index[4:3], direction[6:5], amount[15:7]
  input  logic [15:0]                      in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // status[0], drive_valid[1], drive_motor[3:2], drive_direction[5:4],
  // drive_value[13:6], power_changed[14], power_on[15]
  output logic [15:0]                      out_tdata,
  // drive_is_angle[0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [samc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [samc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [3:0]              kind_mask;
  logic [NUM_MOTORS-1:0]   is_angle;
  logic [6:0]              scale  [NUM_MOTORS];
  logic [7:0]              amin   [NUM_MOTORS];
  logic [7:0]              amax   [NUM_MOTORS];
  logic [7:0]              center [NUM_MOTORS];
  samc_pkg::queue_status_t q_status;
  logic                    q_push, q_pop;
  samc_pkg::cmd_t          q_wdata, q_rdata;
  samc_pkg::result_t       res;

  samc_cfg #(.NUM_MOTORS(NUM_MOTORS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .kind_mask (kind_mask),
    .is_angle  (is_angle),
    .scale     (scale),
    .amin      (amin),
    .amax      (amax),
    .center    (center)
  );

  samc_front #(.NUM_MOTORS(NUM_MOTORS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .kind_mask (kind_mask),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_word    (q_wdata)
  );

  samc_queue #(
    .WIDTH ($bits(samc_pkg::cmd_t)),
    .DEPTH (samc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  samc_back #(.NUM_MOTORS(NUM_MOTORS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_word    (q_rdata),
    .q_pop     (q_pop),
    .is_angle  (is_angle),
    .scale     (scale),
    .amin      (amin),
    .amax      (amax),
    .center    (center),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result word packing
  assign out_tdata = {res.power_on, res.power_changed, res.drive_value,
                      res.drive_direction, res.drive_motor, res.drive_valid, res.status};
  assign out_tuser = res.drive_is_angle;
  assign out_tlast = res.last;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the speed and angle motor command unit.
`timescale 1ns / 1ps

module tb;

  localparam int TB_MOTORS      = samc_pkg::NUM_MOTORS_DEF;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 20;
  // opcodes the block must reject
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [15:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [samc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [samc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  speed_and_angle_motor_command_unit #(.NUM_MOTORS(TB_MOTORS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register copies, as last written
  logic [3:0]  kind_mask_cfg  = samc_pkg::KIND_MASK_RST;
  logic [27:0] scales_cfg     = samc_pkg::SPEED_SCALES_RST;
  logic [31:0] angle_min_cfg  = samc_pkg::ANGLE_MIN_RST;
  logic [31:0] angle_max_cfg  = samc_pkg::ANGLE_MAX_RST;
  logic [31:0] angle_ctr_cfg  = samc_pkg::ANGLE_CENTER_RST;

  // Motor state as the block should hold it
  bit          power_is_on = 1'b0;
  logic [6:0]  speed_sp [TB_MOTORS];
  logic [7:0]  angle_sp [TB_MOTORS];

  logic [15:0]         cmd_q [$];
  samc_pkg::result_t   motor_response_q [$];
  int          cmds_queued = 0;
  int          cmds_accepted = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;

  initial begin
    for (int i = 0; i < TB_MOTORS; i++) begin
      speed_sp[i] = '0;
      angle_sp[i] = samc_pkg::ANGLE_RESET;
    end
  end

  // ---------------- predictor ----------------

  // 8-bit degree field of a packed register, saturated at the top angle
  function automatic int deg_field(input logic [31:0] packed_deg, input int m);
    int v;
    v = packed_deg[8*m +: 8];
    return (v > int'(samc_pkg::ANGLE_MAX)) ? int'(samc_pkg::ANGLE_MAX) : v;
  endfunction

  function automatic int clamp_int(input int lo, input int hi, input int v);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int angle_limit(input int m, input int v);
    return clamp_int(deg_field(angle_min_cfg, m), deg_field(angle_max_cfg, m), v);
  endfunction

  function automatic int scaled_speed(input int m);
    int pct;
    pct = scales_cfg[7*m +: 7];
    if (pct > int'(samc_pkg::SPEED_MAX)) pct = int'(samc_pkg::SPEED_MAX);
    return int'(speed_sp[m]) * pct / 100;
  endfunction

  // Start and stop bring every motor back to rest
  task automatic rest_all_motors();
    for (int i = 0; i < TB_MOTORS; i++) begin
      if (kind_mask_cfg[i]) angle_sp[i] = 8'(angle_limit(i, deg_field(angle_ctr_cfg, i)));
      else speed_sp[i] = '0;
    end
  endtask

  // Update motor state for one command word and queue the words it should produce
  task automatic apply_motor_command(input logic [15:0] w);
    logic [2:0]        op;
    logic [1:0]        m;
    logic [1:0]        dir;
    int                amt;
    int                v;
    bit                was_on;
    samc_pkg::result_t r;
    samc_pkg::result_t d;
    op  = w[2:0];
    m   = w[4:3];
    dir = w[6:5];
    amt = $signed(w[15:7]);
    r = '0;
    r.last = 1'b1;
    if (op == samc_pkg::OP_START) begin
      was_on = power_is_on;
      rest_all_motors();
      if (was_on) begin
        for (int i = 0; i < TB_MOTORS; i++) begin
          d = '0;
          d.drive_valid    = 1'b1;
          d.drive_motor    = 2'(i);
          d.drive_is_angle = kind_mask_cfg[i];
          d.drive_value    = kind_mask_cfg[i] ? angle_sp[i] : 8'd0;
          d.power_on       = 1'b1;
          motor_response_q.push_back(d);
        end
      end
      power_is_on = 1'b1;
      r.power_changed = !was_on;
      r.power_on = 1'b1;
    end else if (op == samc_pkg::OP_STOP) begin
      r.power_changed = power_is_on;
      power_is_on = 1'b0;
      rest_all_motors();
    end else if (op == OP_UNDEF_LO || op == OP_UNDEF_HI || int'(m) >= TB_MOTORS) begin
      r.status = 1'b1;
      r.power_on = power_is_on;
    end else if (op == samc_pkg::OP_SET_SPEED || op == samc_pkg::OP_STEP_SPEED) begin
      r.power_on = power_is_on;
      if (kind_mask_cfg[m]) begin
        r.status = 1'b1;
      end else begin
        v = (op == samc_pkg::OP_SET_SPEED) ? amt : int'(speed_sp[m]) + amt;
        speed_sp[m] = 7'(clamp_int(0, int'(samc_pkg::SPEED_MAX), v));
        if (power_is_on) begin
          r.drive_valid     = 1'b1;
          r.drive_motor     = m;
          r.drive_direction = dir;
          r.drive_value     = 8'(scaled_speed(m));
        end
      end
    end else begin
      r.power_on = power_is_on;
      if (!kind_mask_cfg[m]) begin
        r.status = 1'b1;
      end else begin
        v = (op == samc_pkg::OP_SET_ANGLE) ? amt : int'(angle_sp[m]) + amt;
        angle_sp[m] = 8'(angle_limit(m, v));
        if (power_is_on) begin
          r.drive_valid    = 1'b1;
          r.drive_motor    = m;
          r.drive_is_angle = 1'b1;
          r.drive_value    = angle_sp[m];
        end
      end
    end
    motor_response_q.push_back(r);
  endtask

  // ---------------- driver ----------------

  // Offer the next queued command word when the channel is free, holding back at random by the idle percentage
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_motor_command(in_tdata);
        cmds_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= cmd_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  function automatic string fmt_result(input samc_pkg::result_t r);
    return $sformatf("st=%0d dv=%0d motor=%0d dir=%0d ang=%0d val=%0d pc=%0d pwr=%0d last=%0d",
                     r.status, r.drive_valid, r.drive_motor, r.drive_direction,
                     r.drive_is_angle, r.drive_value, r.power_changed, r.power_on, r.last);
  endfunction

  task automatic check_response();
    samc_pkg::result_t got;
    samc_pkg::result_t want;
    got.status          = out_tdata[0];
    got.drive_valid     = out_tdata[1];
    got.drive_motor     = out_tdata[3:2];
    got.drive_direction = out_tdata[5:4];
    got.drive_is_angle  = out_tuser;
    got.drive_value     = out_tdata[13:6];
    got.power_changed   = out_tdata[14];
    got.power_on        = out_tdata[15];
    got.last            = out_tlast;
    if (motor_response_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result word: %s", fmt_result(got));
    end else begin
      want = motor_response_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected %s\n          actual   %s",
                   fmt_result(want), fmt_result(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_response();
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [15:0] pack_cmd(input logic [2:0] op, input int m,
                                           input int dir, input int amt);
    return {9'(amt), 2'(dir), 2'(m), op};
  endfunction

  // Mostly commands that fit the addressed motor's kind, some noise
  function automatic logic [15:0] rand_command();
    int         sel;
    int         m;
    int         amt;
    logic [2:0] op;
    sel = $urandom_range(99);
    m   = $urandom_range(TB_MOTORS - 1);
    if (sel < 8) op = samc_pkg::OP_START;
    else if (sel < 12) op = samc_pkg::OP_STOP;
    else if (sel < 15) op = ($urandom_range(1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
    else if (sel < 88) begin
      if (kind_mask_cfg[m])
        op = (sel % 2 != 0) ? samc_pkg::OP_STEP_ANGLE : samc_pkg::OP_SET_ANGLE;
      else
        op = (sel % 2 != 0) ? samc_pkg::OP_STEP_SPEED : samc_pkg::OP_SET_SPEED;
    end else op = 3'($urandom_range(3));
    sel = $urandom_range(9);
    if (sel < 2) amt = $urandom_range(511);
    else if (op == samc_pkg::OP_STEP_SPEED || op == samc_pkg::OP_STEP_ANGLE)
      amt = int'($urandom_range(80)) - 40;
    else amt = int'($urandom_range(360)) - 180;
    return pack_cmd(op, m, $urandom_range(3), amt);
  endfunction

  task automatic queue_command(input logic [15:0] w);
    cmd_q.push_back(w);
    cmds_queued++;
  endtask

  // Wait until every queued word was taken and answered, then let the block settle
  task automatic wait_idle();
    while (cmds_accepted != cmds_queued || motor_response_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input samc_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      samc_pkg::REG_KIND_MASK:    kind_mask_cfg = val[3:0];
      samc_pkg::REG_SPEED_SCALES: scales_cfg    = val[27:0];
      samc_pkg::REG_ANGLE_MIN:    angle_min_cfg = val;
      samc_pkg::REG_ANGLE_MAX:    angle_max_cfg = val;
      samc_pkg::REG_ANGLE_CENTER: angle_ctr_cfg = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [3:0] mask, input logic [27:0] scales,
                                input logic [31:0] mins, input logic [31:0] maxs,
                                input logic [31:0] ctrs);
    write_reg(samc_pkg::REG_KIND_MASK, 32'(mask));
    write_reg(samc_pkg::REG_SPEED_SCALES, 32'(scales));
    write_reg(samc_pkg::REG_ANGLE_MIN, mins);
    write_reg(samc_pkg::REG_ANGLE_MAX, maxs);
    write_reg(samc_pkg::REG_ANGLE_CENTER, ctrs);
  endtask

  // Power up, run random commands, power down and drain
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                           input bit one_at_a_time);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_command(pack_cmd(samc_pkg::OP_START, 0, 0, 0));
    for (int k = 0; k < n_items; k++) begin
      queue_command(rand_command());
      if (one_at_a_time) wait_idle();
    end
    queue_command(pack_cmd(samc_pkg::OP_STOP, 0, 0, 0));
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default registers, all speed motors
    queue_command(pack_cmd(samc_pkg::OP_SET_SPEED, 0, 1, 50));    // power off, no drive
    queue_command(pack_cmd(samc_pkg::OP_SET_ANGLE, 1, 0, 45));    // wrong kind
    queue_command(pack_cmd(samc_pkg::OP_STOP, 2, 0, 0));          // stop while off
    queue_command(pack_cmd(samc_pkg::OP_START, 3, 3, 0));         // power on
    queue_command(pack_cmd(samc_pkg::OP_SET_SPEED, 0, 3, 180));   // clamp to top
    queue_command(pack_cmd(samc_pkg::OP_SET_SPEED, 1, 2, -180));  // clamp to zero
    queue_command(pack_cmd(samc_pkg::OP_STEP_SPEED, 2, 1, 255));
    queue_command(pack_cmd(samc_pkg::OP_STEP_SPEED, 2, 1, -256));
    queue_command(pack_cmd(samc_pkg::OP_STEP_SPEED, 3, 1, 37));
    queue_command(pack_cmd(OP_UNDEF_LO, 1, 2, 12));
    queue_command(pack_cmd(OP_UNDEF_HI, 3, 3, -1));
    queue_command(pack_cmd(samc_pkg::OP_STEP_ANGLE, 0, 0, 10));   // wrong kind
    queue_command(pack_cmd(samc_pkg::OP_START, 0, 0, 0));         // restart: one drive per motor
    queue_command(pack_cmd(samc_pkg::OP_STOP, 0, 0, 0));
    wait_idle();

    // Directed: mixed kinds, saturating fields, clamped centers
    write_all_regs(4'b0101, {7'd0, 7'd127, 7'd77, 7'd33},
                   {8'd10, 8'd200, 8'd45, 8'd20}, {8'd170, 8'd255, 8'd135, 8'd160},
                   {8'd0, 8'd250, 8'd90, 8'd95});
    queue_command(pack_cmd(samc_pkg::OP_START, 0, 0, 0));
    queue_command(pack_cmd(samc_pkg::OP_SET_ANGLE, 0, 2, 180));
    queue_command(pack_cmd(samc_pkg::OP_SET_ANGLE, 2, 0, -180));
    queue_command(pack_cmd(samc_pkg::OP_STEP_ANGLE, 0, 0, -256));
    queue_command(pack_cmd(samc_pkg::OP_STEP_ANGLE, 2, 0, 255));
    queue_command(pack_cmd(samc_pkg::OP_SET_SPEED, 0, 1, 20));    // wrong kind
    queue_command(pack_cmd(samc_pkg::OP_SET_SPEED, 1, 2, 100));
    queue_command(pack_cmd(samc_pkg::OP_SET_SPEED, 3, 3, 100));   // zero scale
    queue_command(pack_cmd(samc_pkg::OP_START, 0, 0, 0));         // angles back to center
    queue_command(pack_cmd(samc_pkg::OP_STOP, 0, 0, 0));
    wait_idle();

    // Random: no idling, random registers
    write_all_regs(4'($urandom()), 28'($urandom()), $urandom(), $urandom(), $urandom());
    run_phase(0, 0, PHASE_ITEMS, 1'b0);

    // Random: slow sender, all angle motors, widest limits
    write_all_regs(4'hF, 28'hFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, $urandom());
    run_phase(83, 0, PHASE_ITEMS, 1'b0);

    // Random: slow receiver, all speed motors, zero scales, minimum above maximum
    write_all_regs(4'h0, 28'h000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_5A5A);
    run_phase(0, 83, PHASE_ITEMS, 1'b0);

    // Random: both sides idle now and then
    write_all_regs(4'($urandom()), 28'($urandom()), $urandom(), $urandom(), $urandom());
    run_phase(14, 14, PHASE_ITEMS, 1'b0);

    // Random: one command at a time, each fully answered before the next
    write_all_regs(4'($urandom()), 28'($urandom()), $urandom(), $urandom(), $urandom());
    run_phase(0, 0, PHASE_ITEMS, 1'b1);

    if (mismatches == 0 && motor_response_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/samc_pkg.sv
sv/samc_cfg.sv
sv/samc_front.sv
sv/samc_queue.sv
sv/samc_back.sv
sv/speed_and_angle_motor_command_unit.sv
test/tb.sv
